@@ hw/rtl/ggps_pkg.sv @@
package ggps_pkg;

   // fixed field widths
   localparam int XW = 7;
   localparam int YW = 6;
   localparam int ACTW = 2;
   localparam int STW = 3;
   localparam int CSR_IDXW = 2;
   localparam int CSR_DW = 7;

   // signed probe coordinates, wide enough for one step past either edge
   localparam int CXW = XW + 2;
   localparam int CYW = YW + 2;

   // action codes
   localparam logic [ACTW-1:0] ACT_MARK = 2'd0;
   localparam logic [ACTW-1:0] ACT_RESTART = 2'd1;
   localparam logic [ACTW-1:0] ACT_STEP = 2'd2;

   // configuration register indexes
   localparam logic [CSR_IDXW-1:0] REG_START_X = 2'd0;
   localparam logic [CSR_IDXW-1:0] REG_START_Y = 2'd1;
   localparam logic [CSR_IDXW-1:0] REG_TARGET_X = 2'd2;
   localparam logic [CSR_IDXW-1:0] REG_TARGET_Y = 2'd3;

   typedef enum logic [STW-1:0] {
      ST_ACCEPTED = 3'd0,
      ST_MOVED = 3'd1,
      ST_BLOCKED = 3'd2,
      ST_ARRIVED = 3'd3,
      ST_INVALID = 3'd4
   } status_type;

   // which coordinate the probe unit works on
   typedef enum logic [1:0] {
      PM_CELL,
      PM_START,
      PM_STEP
   } probe_mode_type;

   typedef enum logic [2:0] {
      FSM_CLEAR,
      FSM_IDLE,
      FSM_DECODE,
      FSM_READ,
      FSM_EVAL,
      FSM_FIN
   } fsm_type;

   // candidate cell out of the probe unit
   typedef struct packed {
      logic signed [CXW-1:0] x;
      logic signed [CYW-1:0] y;
      logic in_grid;
      logic at_target;
   } probe_type;

endpackage

@@ hw/rtl/ggps_ram.sv @@
module ggps_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 8192
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // single port, registered read
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;

endmodule

@@ hw/rtl/ggps_probe.sv @@
module ggps_probe #(
   parameter int GRID_W = 128,
   parameter int GRID_H = 64,
   parameter int ADDR_W = 13
) (
   input  ggps_pkg::probe_mode_type   mode,
   input  logic [1:0]                 probe_idx,
   input  logic [ggps_pkg::XW-1:0]    cur_x,
   input  logic [ggps_pkg::YW-1:0]    cur_y,
   input  logic [ggps_pkg::XW-1:0]    start_x,
   input  logic [ggps_pkg::YW-1:0]    start_y,
   input  logic [ggps_pkg::XW-1:0]    target_x,
   input  logic [ggps_pkg::YW-1:0]    target_y,
   input  logic [ggps_pkg::XW-1:0]    cell_x,
   input  logic [ggps_pkg::YW-1:0]    cell_y,
   output ggps_pkg::probe_type        probe,
   output logic [ADDR_W-1:0]          addr
);

   localparam int X_LIM = (GRID_W < 128) ? GRID_W : 128;
   localparam int Y_LIM = (GRID_H < 64) ? GRID_H : 64;
   localparam logic signed [ggps_pkg::CXW-1:0] X_LIM_S = ggps_pkg::CXW'(X_LIM);
   localparam logic signed [ggps_pkg::CYW-1:0] Y_LIM_S = ggps_pkg::CYW'(Y_LIM);
   localparam logic [ADDR_W-1:0] ROW_STRIDE = ADDR_W'(GRID_W);

   logic signed [ggps_pkg::CXW-1:0] base_x, sx, dx, cx;
   logic signed [ggps_pkg::CYW-1:0] base_y, sy, dy, cy;
   logic gt_x, lt_x, gt_y, lt_y, in_grid;

   // direction toward the target
   always_comb begin
      gt_x = target_x > cur_x;
      lt_x = target_x < cur_x;
      gt_y = target_y > cur_y;
      lt_y = target_y < cur_y;
      sx = gt_x ? 9'sd1 : (lt_x ? -9'sd1 : 9'sd0);
      sy = gt_y ? 8'sd1 : (lt_y ? -8'sd1 : 8'sd0);
   end

   // candidate cell for the current mode and probe number
   always_comb begin
      base_x = {2'b00, cur_x};
      base_y = {2'b00, cur_y};
      dx = '0;
      dy = '0;
      cx = {2'b00, cell_x};
      cy = {2'b00, cell_y};
      unique case (mode)
         ggps_pkg::PM_CELL: begin
            cx = {2'b00, cell_x};
            cy = {2'b00, cell_y};
         end
         ggps_pkg::PM_START: begin
            cx = {2'b00, start_x};
            cy = {2'b00, start_y};
         end
         ggps_pkg::PM_STEP: begin
            if (sx != 9'sd0 && sy != 8'sd0) begin
               // diagonal first, then along x, then along y
               dx = (probe_idx == 2'd2) ? 9'sd0 : sx;
               dy = (probe_idx == 2'd1) ? 8'sd0 : sy;
            end else if (sy == 8'sd0) begin
               // straight along x, then sidestep down and up
               dx = sx;
               dy = (probe_idx == 2'd1) ? 8'sd1 : ((probe_idx == 2'd2) ? -8'sd1 : 8'sd0);
            end else begin
               // straight along y, then sidestep right and left
               dy = sy;
               dx = (probe_idx == 2'd1) ? 9'sd1 : ((probe_idx == 2'd2) ? -9'sd1 : 9'sd0);
            end
            cx = base_x + dx;
            cy = base_y + dy;
         end
         default: begin
            cx = {2'b00, cell_x};
            cy = {2'b00, cell_y};
         end
      endcase
   end

   // grid limits and cell address
   always_comb begin
      in_grid = (cx >= 9'sd0) && (cx < X_LIM_S) && (cy >= 8'sd0) && (cy < Y_LIM_S);
      addr = in_grid ? (ADDR_W'(cy[ggps_pkg::YW-1:0]) * ROW_STRIDE
                        + ADDR_W'(cx[ggps_pkg::XW-1:0])) : '0;
      probe.x = cx;
      probe.y = cy;
      probe.in_grid = in_grid;
      probe.at_target = !gt_x && !lt_x && !gt_y && !lt_y;
   end

endmodule

@@ hw/rtl/greedy_grid_path_stepper.sv @@
// Sequence per item: accept, DECODE, then FIN for a mark, an arrival or an unused action,
// one READ and EVAL for a restart, or a READ and EVAL per probed cell for a step (up to 3 cells).
// One item at a time; FIN waits while an earlier result is not yet taken (rsp_ready low);
// every probe is a read then a check on the one occupancy memory port via the probe unit.
// Reset: clears position and registers, then sweeps all GRID_W*GRID_H cells clearing
// the occupancy memory one cell a cycle; no item is taken until the sweep ends.
module greedy_grid_path_stepper #(
   parameter int GRID_W = 128,
   parameter int GRID_H = 64
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [ggps_pkg::ACTW-1:0]       req_action,
   input  logic [ggps_pkg::XW-1:0]         req_cell_x,
   input  logic [ggps_pkg::YW-1:0]         req_cell_y,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [ggps_pkg::STW-1:0]        rsp_status,
   output logic [ggps_pkg::XW-1:0]         rsp_pos_x,
   output logic [ggps_pkg::YW-1:0]         rsp_pos_y,
   input  logic                            csr_we,
   input  logic [ggps_pkg::CSR_IDXW-1:0]   csr_index,
   input  logic [ggps_pkg::CSR_DW-1:0]     csr_wdata
);

   localparam int DEPTH = GRID_W * GRID_H;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);

   ggps_pkg::fsm_type state_ff, state_in;
   ggps_pkg::status_type status_ff, status_in;
   ggps_pkg::probe_mode_type mode;
   ggps_pkg::probe_type probe;

   logic [ggps_pkg::XW-1:0] start_x_ff, target_x_ff, cur_x_ff, cur_x_in, cell_x_ff;
   logic [ggps_pkg::YW-1:0] start_y_ff, target_y_ff, cur_y_ff, cur_y_in, cell_y_ff;
   logic [ggps_pkg::ACTW-1:0] act_ff;
   logic [1:0] k_ff, k_in;
   logic [ADDR_W-1:0] clr_cnt_ff, probe_addr, ram_addr;
   logic ram_we, ram_wdata, ram_rdata;
   logic cell_free, load_rsp, accept;
   logic rsp_valid_ff, rsp_valid_in;
   ggps_pkg::status_type rsp_status_ff;
   logic [ggps_pkg::XW-1:0] rsp_pos_x_ff;
   logic [ggps_pkg::YW-1:0] rsp_pos_y_ff;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         start_x_ff <= '0;
         start_y_ff <= '0;
         target_x_ff <= '0;
         target_y_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            ggps_pkg::REG_START_X: start_x_ff <= csr_wdata;
            ggps_pkg::REG_START_Y: start_y_ff <= csr_wdata[ggps_pkg::YW-1:0];
            ggps_pkg::REG_TARGET_X: target_x_ff <= csr_wdata;
            ggps_pkg::REG_TARGET_Y: target_y_ff <= csr_wdata[ggps_pkg::YW-1:0];
            default: ;
         endcase
      end
   end

   // probe unit mode follows the latched action
   always_comb begin
      if (act_ff == ggps_pkg::ACT_MARK) begin
         mode = ggps_pkg::PM_CELL;
      end else if (act_ff == ggps_pkg::ACT_RESTART) begin
         mode = ggps_pkg::PM_START;
      end else begin
         mode = ggps_pkg::PM_STEP;
      end
   end

   ggps_probe #(
      .GRID_W (GRID_W),
      .GRID_H (GRID_H),
      .ADDR_W (ADDR_W)
   ) u_probe (
      .mode      (mode),
      .probe_idx (k_ff),
      .cur_x     (cur_x_ff),
      .cur_y     (cur_y_ff),
      .start_x   (start_x_ff),
      .start_y   (start_y_ff),
      .target_x  (target_x_ff),
      .target_y  (target_y_ff),
      .cell_x    (cell_x_ff),
      .cell_y    (cell_y_ff),
      .probe     (probe),
      .addr      (probe_addr)
   );

   ggps_ram #(
      .WIDTH (1),
      .DEPTH (DEPTH)
   ) u_occ (
      .clock (clock),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
   );

   assign cell_free = probe.in_grid && !ram_rdata;
   assign accept = req_valid && req_ready;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ggps_pkg::FSM_CLEAR: begin
            if (clr_cnt_ff == LAST_ADDR) state_in = ggps_pkg::FSM_IDLE;
         end
         ggps_pkg::FSM_IDLE: begin
            if (req_valid) state_in = ggps_pkg::FSM_DECODE;
         end
         ggps_pkg::FSM_DECODE: begin
            if (act_ff == ggps_pkg::ACT_RESTART) begin
               state_in = ggps_pkg::FSM_READ;
            end else if (act_ff == ggps_pkg::ACT_STEP && !probe.at_target) begin
               state_in = ggps_pkg::FSM_READ;
            end else begin
               state_in = ggps_pkg::FSM_FIN;
            end
         end
         ggps_pkg::FSM_READ: state_in = ggps_pkg::FSM_EVAL;
         ggps_pkg::FSM_EVAL: begin
            if (act_ff == ggps_pkg::ACT_STEP && !cell_free && k_ff != 2'd2) begin
               state_in = ggps_pkg::FSM_READ;
            end else begin
               state_in = ggps_pkg::FSM_FIN;
            end
         end
         ggps_pkg::FSM_FIN: begin
            if (load_rsp) state_in = ggps_pkg::FSM_IDLE;
         end
         default: state_in = ggps_pkg::FSM_CLEAR;
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      req_ready = 1'b0;
      ram_we = 1'b0;
      ram_wdata = 1'b1;
      ram_addr = probe_addr;
      load_rsp = 1'b0;
      unique case (state_ff)
         ggps_pkg::FSM_CLEAR: begin
            ram_we = 1'b1;
            ram_wdata = 1'b0;
            ram_addr = clr_cnt_ff;
         end
         ggps_pkg::FSM_IDLE: req_ready = 1'b1;
         ggps_pkg::FSM_DECODE: begin
            ram_we = (act_ff == ggps_pkg::ACT_MARK) && probe.in_grid;
         end
         ggps_pkg::FSM_READ: ;
         ggps_pkg::FSM_EVAL: begin
            ram_we = (act_ff == ggps_pkg::ACT_STEP) && cell_free;
         end
         ggps_pkg::FSM_FIN: load_rsp = !rsp_valid_ff || rsp_ready;
         default: ;
      endcase
   end

   // item status, probe number and position
   always_comb begin
      status_in = status_ff;
      k_in = k_ff;
      cur_x_in = cur_x_ff;
      cur_y_in = cur_y_ff;
      if (state_ff == ggps_pkg::FSM_DECODE) begin
         k_in = 2'd0;
         if (act_ff == ggps_pkg::ACT_MARK) begin
            status_in = probe.in_grid ? ggps_pkg::ST_ACCEPTED : ggps_pkg::ST_INVALID;
         end else if (act_ff == ggps_pkg::ACT_STEP) begin
            status_in = ggps_pkg::ST_ARRIVED;
         end else begin
            status_in = ggps_pkg::ST_INVALID;
         end
      end else if (state_ff == ggps_pkg::FSM_EVAL) begin
         if (act_ff == ggps_pkg::ACT_RESTART) begin
            status_in = cell_free ? ggps_pkg::ST_ACCEPTED : ggps_pkg::ST_INVALID;
         end else if (cell_free) begin
            status_in = ggps_pkg::ST_MOVED;
         end else begin
            status_in = ggps_pkg::ST_BLOCKED;
            k_in = k_ff + 2'd1;
         end
         if (cell_free) begin
            cur_x_in = probe.x[ggps_pkg::XW-1:0];
            cur_y_in = probe.y[ggps_pkg::YW-1:0];
         end
      end
   end

   // sequencer and position registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ggps_pkg::FSM_CLEAR;
         clr_cnt_ff <= '0;
         cur_x_ff <= '0;
         cur_y_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ggps_pkg::FSM_CLEAR) clr_cnt_ff <= clr_cnt_ff + 1'b1;
         cur_x_ff <= cur_x_in;
         cur_y_ff <= cur_y_in;
      end
   end

   // item payload and working registers
   always_ff @(posedge clock) begin
      if (accept) begin
         act_ff <= req_action;
         cell_x_ff <= req_cell_x;
         cell_y_ff <= req_cell_y;
      end
      status_ff <= status_in;
      k_ff <= k_in;
   end

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_status_ff <= status_ff;
         rsp_pos_x_ff <= cur_x_ff;
         rsp_pos_y_ff <= cur_y_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_pos_x = rsp_pos_x_ff;
   assign rsp_pos_y = rsp_pos_y_ff;

   // one item in flight: no second accept straight after the first
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      accept |=> !req_ready)
      else $error("item accepted while another is in progress");

   // an arrived result always sits on the target
   a_arrived_on_target: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == ggps_pkg::ST_ARRIVED) |->
         (rsp_pos_x == target_x_ff && rsp_pos_y == target_y_ff))
      else $error("arrived reported away from target");

   // a move changes the position by one cell at most in each direction
   a_move_one_cell: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ggps_pkg::FSM_EVAL && act_ff == ggps_pkg::ACT_STEP && cell_free) |=>
         ((cur_x_ff == $past(cur_x_ff) || cur_x_ff == $past(cur_x_ff) + 7'd1
           || cur_x_ff == $past(cur_x_ff) - 7'd1)
          && (cur_y_ff == $past(cur_y_ff) || cur_y_ff == $past(cur_y_ff) + 6'd1
           || cur_y_ff == $past(cur_y_ff) - 6'd1)))
      else $error("step moved further than one cell");

endmodule
